// ----- hw/rtl/azimuthal_average_histogram_unit_defines.svh -----
// Assertion macros shared by the azimuthal average histogram RTL.
// No dependencies; included by the files that carry assertions.
`ifndef AZIMUTHAL_AVERAGE_HISTOGRAM_UNIT_DEFINES_SVH
`define AZIMUTHAL_AVERAGE_HISTOGRAM_UNIT_DEFINES_SVH

// Checked on every rising edge, switched off while reset is asserted.
`define AAH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define AAH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/aah_pkg.sv -----
// Package of the azimuthal average histogram unit: sizes, codes and types.
// Used by every module of the block but aah_ram; depends on nothing.
package aah_pkg;

  // Frame and table sizes.
  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int BinCount  = 1024;

  // Field widths fixed by the interface.
  localparam int DimW    = 10;
  localparam int AspW    = 16;
  localparam int PixW    = 32;
  localparam int SelW    = 10;
  localparam int ActionW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;
  localparam int FracW   = 12;

  // Derived widths.
  localparam int PosW   = $clog2((MaxWidth > MaxHeight) ? MaxWidth : MaxHeight);
  localparam int BinW   = $clog2(BinCount);
  localparam int SumW   = 52;
  localparam int CountW = 19;
  localparam int EntW   = SumW + CountW;
  localparam int RadW   = PosW + AspW;
  localparam int SqW    = 2 * RadW + 2;
  localparam int RootW  = SqW / 2;
  localparam int NumW   = 60;
  localparam int DenW   = 25;

  localparam int InDataW  = 48;
  localparam int OutDataW = 160;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Item kinds on the input channel.
  typedef enum logic [ActionW-1:0] {
    ACT_PIXEL = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_ASPECT = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_e;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Clamp a frame dimension to the range 2 to hi.
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    r = v;
    if (v < DimW'(2)) r = DimW'(2);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- hw/rtl/aah_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the bin store.
module aah_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write and one registered read each cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/aah_isqrt.sv -----
// Iterative integer square root, one root bit per cycle.
// Depends on aah_pkg.
module aah_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [aah_pkg::SqW-1:0]  operand_i,
  output aah_pkg::unit_stat_t      stat_o,
  output logic [aah_pkg::RootW-1:0] root_o
);
  import aah_pkg::*;

  localparam int CntW = $clog2(RootW);

  logic [SqW-1:0]     rad_q;
  logic [RootW:0]     rem_q;
  logic [RootW-1:0]   root_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;
  logic [RootW+1:0]   rem_sh, trial, diff;
  logic               fits;

  // Bring in the next pair of operand bits and try the next root bit.
  assign rem_sh = {rem_q[RootW-1:0], rad_q[SqW-1:SqW-2]};
  assign trial  = {root_q, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= operand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? diff[RootW:0] : rem_sh[RootW:0];
      root_q <= {root_q[RootW-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

// ----- hw/rtl/aah_div.sv -----
// Iterative restoring divider for unsigned operands, one quotient bit per cycle.
// Depends on aah_pkg.
module aah_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [aah_pkg::NumW-1:0] num_i,
  input  logic [aah_pkg::DenW-1:0] den_i,
  output aah_pkg::unit_stat_t      stat_o,
  output logic [aah_pkg::NumW-1:0] quo_o
);
  import aah_pkg::*;

  localparam int CntW = $clog2(NumW);

  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW:0]   rem_sh, diff;
  logic            fits;

  // Shift in the next numerator bit and subtract where the divisor fits.
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = (rem_sh >= {1'b0, den_q});

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient bits replace the numerator bits as they go.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], fits};
      rem_q <= fits ? diff[DenW-1:0] : rem_sh[DenW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = num_q;

endmodule

// ----- hw/rtl/azimuthal_average_histogram_unit.sv -----
// Top level of the azimuthal average histogram unit.
// Depends on aah_pkg, aah_ram, aah_isqrt, aah_div and the assertion macro header.
//
// Usage:
// Items arrive on the s_axis channel; tuser carries the action (pixel, read bin,
// clear). Pixels come in raster order and are binned by rounded radius about the
// frame centre into a 1024-entry store of sums and counts held in one RAM.
// A read item gives one result on m_axis: the bin mean and count, the highest bin
// used, the frame minimum and maximum and the display floor. Pixel and clear
// items give no result.
// A pixel item occupies the block through the bit-serial square root and the
// RAM read-modify-write. A read item occupies it through two passes of the
// bit-serial divider. A clear item writes one RAM entry per cycle over all 1024
// entries. After reset the same clearing pass runs before the first item is
// taken; configuration writes are taken at any time.
// The result sits in an output register; a stalled receiver holds it, and the
// block keeps taking items until a further read result is ready to load.
`include "azimuthal_average_histogram_unit_defines.svh"

module azimuthal_average_histogram_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [aah_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [aah_pkg::CfgW-1:0]     cfg_data_i,
  // Input items.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata, from bit 0: pixel_value[31:0], bin_select[41:32], zero fill.
  input  logic [aah_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: action[1:0].
  input  logic [aah_pkg::ActionW-1:0]  s_axis_tuser,
  // Result items.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata, from bit 0: bin_mean[31:0], bin_pixels[50:32], bin_empty[51],
  // highest_bin[61:52], range_low[93:62], range_high[125:94],
  // display_floor[157:126], zero fill.
  output logic [aah_pkg::OutDataW-1:0] m_axis_tdata
);
  import aah_pkg::*;

  typedef enum logic [14:0] {
    ST_CLEAR  = 15'b000000000000001,
    ST_IDLE   = 15'b000000000000010,
    ST_MUL    = 15'b000000000000100,
    ST_ROOTGO = 15'b000000000001000,
    ST_ROOT   = 15'b000000000010000,
    ST_RD     = 15'b000000000100000,
    ST_WR     = 15'b000000001000000,
    ST_RRD    = 15'b000000010000000,
    ST_RDAT   = 15'b000000100000000,
    ST_MGO    = 15'b000001000000000,
    ST_MWAIT  = 15'b000010000000000,
    ST_FMUL   = 15'b000100000000000,
    ST_FGO    = 15'b001000000000000,
    ST_FWAIT  = 15'b010000000000000,
    ST_OUT    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [DimW-1:0] fw_q, fh_q;
  logic [AspW-1:0] asp_q;

  // Frame statistics.
  logic [PosW-1:0]         col_q, row_q;
  logic signed [PixW-1:0]  min_q, max_q;
  logic signed [SumW-1:0]  ws_q;
  logic [CountW-1:0]       wc_q;
  logic [BinW-1:0]         top_q;
  logic [BinW-1:0]         clr_cnt_q;

  // Item working registers.
  logic signed [PixW-1:0]  pix_q;
  logic [PosW-1:0]         adx_q, ady_q;
  logic [2*PosW-1:0]       adxsq_q;
  logic [RadW-1:0]         ry_q;
  logic [BinW-1:0]         bin_q;
  logic [SelW-1:0]         sel_q;
  logic [CountW-1:0]       cnt_q;
  logic signed [SumW-1:0]  sumr_q;
  logic signed [PixW-1:0]  mean_q, floor_q;
  logic signed [SumW-1:0]  prod_q;
  logic                    fneg_q;

  // Output register.
  logic                    mval_q;
  logic [OutDataW-1:0]     mdata_q;

  // Input item fields.
  logic                    s_acc;
  action_e                 act;
  logic signed [PixW-1:0]  pix_in;
  logic [SelW-1:0]         sel_in;

  assign s_acc  = s_axis_tvalid && s_axis_tready;
  assign act    = action_e'(s_axis_tuser);
  assign pix_in = s_axis_tdata[PixW-1:0];
  assign sel_in = s_axis_tdata[PixW+:SelW];
  assign s_axis_tready = (state_q == ST_IDLE);

  // Frame geometry from the configuration.
  logic [DimW-1:0]   w, h, xm, ym, cx, cy, adx_c, ady_c;
  logic [DimW+1:0]   w3, w5, h3, h5, cx_e, cy_e;
  logic              at_origin, off_axes, in_win, col_wrap, row_wrap;

  assign w    = clamp_dim(fw_q, DimW'(MaxWidth));
  assign h    = clamp_dim(fh_q, DimW'(MaxHeight));
  assign xm   = w >> 1;
  assign ym   = h >> 1;
  assign cx   = DimW'(col_q);
  assign cy   = DimW'(row_q);
  assign w3   = ({2'b00, w} + {1'b0, w, 1'b0}) >> 3;
  assign w5   = ({2'b00, w} + {w, 2'b00}) >> 3;
  assign h3   = ({2'b00, h} + {1'b0, h, 1'b0}) >> 3;
  assign h5   = ({2'b00, h} + {h, 2'b00}) >> 3;
  assign cx_e = (DimW+2)'(col_q);
  assign cy_e = (DimW+2)'(row_q);

  assign adx_c     = (cx >= xm) ? cx - xm : xm - cx;
  assign ady_c     = (cy >= ym) ? cy - ym : ym - cy;
  assign at_origin = (col_q == '0) && (row_q == '0);
  assign off_axes  = (cx != xm) && (cy != ym);
  assign in_win    = (cx_e > w3) && (cx_e < w5) && (cy_e > h3) && (cy_e < h5) &&
                     (wc_q < CountMax);
  assign col_wrap  = (cx + DimW'(1)) >= w;
  assign row_wrap  = (cy + DimW'(1)) >= h;

  // Bin store: sum in the low bits, count above it.
  logic             ram_we;
  logic [BinW-1:0]  ram_waddr, ram_raddr;
  logic [EntW-1:0]  ram_wdata, ram_rdata;
  logic signed [SumW-1:0] ent_sum;
  logic [CountW-1:0] ent_cnt;
  logic              ent_room;

  assign ent_sum  = ram_rdata[SumW-1:0];
  assign ent_cnt  = ram_rdata[SumW+:CountW];
  assign ent_room = (ent_cnt < CountMax);

  assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_WR) && ent_room);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : bin_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 :
                     {ent_cnt + CountW'(1), ent_sum + SumW'(pix_q)};
  assign ram_raddr = (state_q == ST_RRD) ? BinW'(sel_q) : bin_q;

  aah_ram #(
    .Width (EntW),
    .Depth (BinCount)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Radius: squared distance in Q.24, then the square root unit.
  logic [2*RadW-1:0]  rysq;
  logic [SqW-1:0]     sq_c;
  unit_stat_t         sqrt_stat;
  logic [RootW-1:0]   root;
  logic [RootW:0]     root_rnd;
  logic [RootW-FracW:0] bin_raw;

  assign rysq     = ry_q * ry_q;
  assign sq_c     = (SqW'(adxsq_q) << (2 * FracW)) + SqW'(rysq);
  assign root_rnd = (RootW+1)'(root) + (RootW+1)'(1 << (FracW - 1));
  assign bin_raw  = root_rnd[RootW:FracW];

  aah_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_ROOTGO),
    .operand_i (sq_c),
    .stat_o    (sqrt_stat),
    .root_o    (root)
  );

  // Shared divider: bin mean first, then the display floor.
  logic [SumW-1:0]         smag;
  logic signed [NumW-1:0]  fnum;
  logic [NumW-1:0]         fmag;
  logic [DenW-1:0]         fden;
  logic [NumW-1:0]         div_num;
  logic [DenW-1:0]         div_den;
  logic                    div_start;
  unit_stat_t              div_stat;
  logic [NumW-1:0]         quo;
  logic [PixW-1:0]         quo_lo;

  assign smag = sumr_q[SumW-1] ? SumW'(-sumr_q) : SumW'(sumr_q);
  assign fnum = (wc_q == '0) ? NumW'(min_q) :
                NumW'(prod_q) + (NumW'(ws_q) <<< 4) + (NumW'(ws_q) <<< 1) + NumW'(ws_q);
  assign fmag = fnum[NumW-1] ? NumW'(-fnum) : NumW'(fnum);
  assign fden = (wc_q == '0) ? DenW'(20) :
                (DenW'(wc_q) << 4) + (DenW'(wc_q) << 2);

  always_comb begin
    div_start = 1'b0;
    div_num   = (NumW'(smag) << 1) + NumW'(cnt_q);
    div_den   = DenW'({cnt_q, 1'b0});
    if (state_q == ST_MGO) begin
      div_start = 1'b1;
    end else if (state_q == ST_FGO) begin
      div_start = 1'b1;
      div_num   = (fmag << 1) + NumW'(fden);
      div_den   = fden << 1;
    end
  end

  aah_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  assign quo_lo = quo[PixW-1:0];

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == BinW'(BinCount - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_acc) begin
          case (act)
            ACT_PIXEL: state_d = ST_MUL;
            ACT_READ:  state_d = ST_RRD;
            ACT_CLEAR: state_d = ST_CLEAR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL:    state_d = ST_ROOTGO;
      ST_ROOTGO: state_d = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_stat.done) state_d = ST_RD;
      end
      ST_RD:     state_d = ST_WR;
      ST_WR:     state_d = ST_IDLE;
      ST_RRD:    state_d = ST_RDAT;
      ST_RDAT:   state_d = ST_MGO;
      ST_MGO:    state_d = ST_MWAIT;
      ST_MWAIT: begin
        if (div_stat.done) state_d = ST_FMUL;
      end
      ST_FMUL:   state_d = ST_FGO;
      ST_FGO:    state_d = ST_FWAIT;
      ST_FWAIT: begin
        if (div_stat.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!mval_q || m_axis_tready) state_d = ST_IDLE;
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Control state, frame statistics and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      fw_q      <= DimW'(512);
      fh_q      <= DimW'(512);
      asp_q     <= AspW'(4096);
      col_q     <= '0;
      row_q     <= '0;
      min_q     <= '0;
      max_q     <= '0;
      ws_q      <= '0;
      wc_q      <= '0;
      top_q     <= '0;
      mval_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDTH:  fw_q  <= cfg_data_i[DimW-1:0];
          CFG_HEIGHT: fh_q  <= cfg_data_i[DimW-1:0];
          CFG_ASPECT: asp_q <= cfg_data_i[AspW-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + BinW'(1);
      end

      // Pixel statistics that need no store access are settled on acceptance.
      if (s_acc && (act == ACT_PIXEL)) begin
        if (at_origin) begin
          min_q <= pix_in;
          max_q <= pix_in;
        end else if (off_axes) begin
          if (pix_in < min_q) min_q <= pix_in;
          if (pix_in > max_q) max_q <= pix_in;
        end
        if (in_win) begin
          ws_q <= ws_q + SumW'(pix_in);
          wc_q <= wc_q + CountW'(1);
        end
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : row_q + PosW'(1);
        end else begin
          col_q <= col_q + PosW'(1);
        end
      end else if (s_acc && (act == ACT_CLEAR)) begin
        clr_cnt_q <= '0;
        col_q     <= '0;
        row_q     <= '0;
        min_q     <= '0;
        max_q     <= '0;
        ws_q      <= '0;
        wc_q      <= '0;
        top_q     <= '0;
      end

      if ((state_q == ST_WR) && (bin_q > top_q)) begin
        top_q <= bin_q;
      end

      // Output register.
      if ((state_q == ST_OUT) && (!mval_q || m_axis_tready)) begin
        mval_q <= 1'b1;
      end else if (m_axis_tready) begin
        mval_q <= 1'b0;
      end
    end
  end

  // Working registers of the item in progress.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pix_q <= pix_in;
      sel_q <= sel_in;
      adx_q <= adx_c[PosW-1:0];
      ady_q <= ady_c[PosW-1:0];
    end
    if (state_q == ST_MUL) begin
      adxsq_q <= adx_q * adx_q;
      ry_q    <= ady_q * asp_q;
    end
    if ((state_q == ST_ROOT) && sqrt_stat.done) begin
      bin_q <= (bin_raw > (RootW-FracW+1)'(BinCount - 1)) ? BinW'(BinCount - 1) :
               BinW'(bin_raw);
    end
    if (state_q == ST_RDAT) begin
      if (int'(sel_q) < BinCount) begin
        cnt_q  <= ent_cnt;
        sumr_q <= ent_sum;
      end else begin
        cnt_q  <= '0;
        sumr_q <= '0;
      end
    end
    if ((state_q == ST_MWAIT) && div_stat.done) begin
      if (cnt_q == '0) mean_q <= '0;
      else mean_q <= sumr_q[SumW-1] ? -quo_lo : quo_lo;
    end
    if (state_q == ST_FMUL) begin
      prod_q <= min_q * $signed({1'b0, wc_q});
    end
    if (state_q == ST_FGO) begin
      fneg_q <= fnum[NumW-1];
    end
    if ((state_q == ST_FWAIT) && div_stat.done) begin
      floor_q <= fneg_q ? -quo_lo : quo_lo;
    end
    if ((state_q == ST_OUT) && (!mval_q || m_axis_tready)) begin
      mdata_q <= {2'b00, floor_q, max_q, min_q, top_q, (cnt_q == '0), cnt_q, mean_q};
    end
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;

  // Checks.
  `AAH_ASSERT(a_clear_takes_nothing, clk_i, rst_ni,
              (state_q == ST_CLEAR) |-> !s_axis_tready, "item taken during clearing pass")
  `AAH_ASSERT(a_result_from_out, clk_i, rst_ni,
              $rose(mval_q) |-> $past(state_q == ST_OUT), "result loaded outside final step")
  `AAH_ASSERT(a_div_free_on_start, clk_i, rst_ni,
              div_start |-> !div_stat.busy, "divider started while busy")
  `AAH_ASSERT(a_write_after_read, clk_i, rst_ni,
              (state_q == ST_WR) |-> $past(state_q == ST_RD), "bin written without a read")
  `AAH_ASSERT_ALWAYS(a_reset_no_result, clk_i,
                     !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench of the azimuthal average histogram unit.
// Depends on aah_pkg and azimuthal_average_histogram_unit; predicts every read result.
module tb;
  import aah_pkg::*;

  // Clock, reset and block ports.
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // tdata, from bit 0: pixel_value[31:0], bin_select[41:32], zero fill.
  logic [InDataW-1:0]  s_axis_tdata;
  // tuser: action[1:0].
  logic [ActionW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // tdata, from bit 0: bin_mean, bin_pixels, bin_empty, highest_bin,
  // range_low, range_high, display_floor, zero fill.
  logic [OutDataW-1:0] m_axis_tdata;

  // One expected read result.
  typedef struct {
    logic signed [31:0] mean;
    logic [18:0]        pixels;
    logic               empty;
    logic [9:0]         top;
    logic signed [31:0] low;
    logic signed [31:0] high;
    logic signed [31:0] floor_v;
  } bin_report_t;

  bin_report_t expected_reports[$];
  int          error_count = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_off_cycles = 0;

  // Shadow of the block's configuration and stores.
  int unsigned      width_reg, height_reg, aspect_reg;
  int unsigned      col_pos, row_pos;
  longint           sum_store[BinCount];
  int unsigned      count_store[BinCount];
  int unsigned      top_used;
  int               min_seen, max_seen;
  longint           win_sum;
  int unsigned      win_count;

  azimuthal_average_histogram_unit DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Prediction.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void wipe_stores();
    foreach (sum_store[i]) begin
      sum_store[i] = 0;
      count_store[i] = 0;
    end
    top_used = 0;
    min_seen = 0;
    max_seen = 0;
    win_sum = 0;
    win_count = 0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void accumulate_pixel(int p);
    int unsigned     w, h, xm, ym;
    longint unsigned adx, ady, ry, s, bin;
    w = clamp_size(width_reg, MaxWidth);
    h = clamp_size(height_reg, MaxHeight);
    xm = w / 2;
    ym = h / 2;
    adx = (col_pos >= xm) ? col_pos - xm : xm - col_pos;
    ady = (row_pos >= ym) ? row_pos - ym : ym - row_pos;
    ry = ady * aspect_reg;
    s = ((adx * adx) << 24) + ry * ry;
    bin = (root_floor(s) + 2048) >> 12;
    if (bin > BinCount - 1) bin = BinCount - 1;
    if (count_store[bin] < 524287) begin
      sum_store[bin] += p;
      count_store[bin]++;
    end
    if (bin > top_used) top_used = bin;
    // Pixel (0,0) loads the range; the centre row and column are skipped.
    if (col_pos == 0 && row_pos == 0) begin
      min_seen = p;
      max_seen = p;
    end else if (col_pos != xm && row_pos != ym) begin
      if (p < min_seen) min_seen = p;
      if (p > max_seen) max_seen = p;
    end
    if (col_pos > (3 * w) / 8 && col_pos < (5 * w) / 8 &&
        row_pos > (3 * h) / 8 && row_pos < (5 * h) / 8 && win_count < 524287) begin
      win_sum += p;
      win_count++;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic bin_report_t report_of_bin(int unsigned sel);
    bin_report_t r;
    longint      fl;
    r.pixels = count_store[sel];
    r.empty = (count_store[sel] == 0);
    r.mean = r.empty ? 32'sd0 : 32'(round_div(sum_store[sel], count_store[sel]));
    r.top = top_used;
    r.low = min_seen;
    r.high = max_seen;
    if (win_count != 0)
      fl = round_div(longint'(min_seen) * win_count + 19 * win_sum, 20 * win_count);
    else
      fl = round_div(min_seen, 20);
    r.floor_v = 32'(fl);
    return r;
  endfunction

  // Offers one item, waits for it to be taken, then updates the shadow.
  task automatic send_item(action_e act, logic [31:0] pix, logic [9:0] sel);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {6'b0, sel, pix};
    do @(posedge clk_i); while (!s_axis_tready);
    case (act)
      ACT_PIXEL: accumulate_pixel(int'(pix));
      ACT_READ:  expected_reports.push_back(report_of_bin(sel));
      ACT_CLEAR: wipe_stores();
      default: ;
    endcase
  endtask

  // Lets the block drain, including a possible clearing pass, then writes all registers.
  task automatic set_frame(int unsigned w, int unsigned h, int unsigned asp);
    s_axis_tvalid <= 1'b0;
    wait (expected_reports.size() == 0);
    repeat (1100) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WIDTH;
    cfg_data_i <= CfgW'(w);
    @(posedge clk_i);
    cfg_idx_i <= CFG_HEIGHT;
    cfg_data_i <= CfgW'(h);
    @(posedge clk_i);
    cfg_idx_i <= CFG_ASPECT;
    cfg_data_i <= CfgW'(asp);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg = w & 10'h3FF;
    height_reg = h & 10'h3FF;
    aspect_reg = asp & 16'hFFFF;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Result checking.
  always @(posedge clk_i) begin
    bin_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_reports.pop_front();
        if ($signed(m_axis_tdata[31:0]) != want.mean)
          report_mismatch("bin_mean", $signed(m_axis_tdata[31:0]), want.mean);
        if (m_axis_tdata[50:32] != want.pixels)
          report_mismatch("bin_pixels", m_axis_tdata[50:32], want.pixels);
        if (m_axis_tdata[51] != want.empty)
          report_mismatch("bin_empty", m_axis_tdata[51], want.empty);
        if (m_axis_tdata[61:52] != want.top)
          report_mismatch("highest_bin", m_axis_tdata[61:52], want.top);
        if ($signed(m_axis_tdata[93:62]) != want.low)
          report_mismatch("range_low", $signed(m_axis_tdata[93:62]), want.low);
        if ($signed(m_axis_tdata[125:94]) != want.high)
          report_mismatch("range_high", $signed(m_axis_tdata[125:94]), want.high);
        if ($signed(m_axis_tdata[157:126]) != want.floor_v)
          report_mismatch("display_floor", $signed(m_axis_tdata[157:126]), want.floor_v);
      end
    end
  end

  // Receiver: a long hold-off counted down in cycles, random stalls otherwise.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(65536 * 8)) - 32'd262144;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] pick_bin();
    return ($urandom_range(1)) ? 10'($urandom_range(40)) : 10'($urandom);
  endfunction

  // Directed tests.
  task automatic test_empty_after_reset();
    send_item(ACT_READ, 32'h0, 10'd0);
    send_item(ACT_READ, 32'hFFFF_FFFF, 10'd1023);
  endtask

  task automatic test_small_frame();
    set_frame(4, 4, 4096);
    send_item(ACT_CLEAR, 32'h0, 10'd0);
    for (int i = 0; i < 16; i++) send_item(ACT_PIXEL, pick_pixel(), 10'd0);
    for (int b = 0; b < 4; b++) send_item(ACT_READ, 32'h0, 10'(b));
  endtask

  // Out-of-range sizes clamp; a steep aspect drives the bin into saturation.
  task automatic test_clamp_and_saturation();
    set_frame(0, 1023, 65535);
    send_item(ACT_CLEAR, 32'h0, 10'd0);
    for (int i = 0; i < 6; i++) send_item(ACT_PIXEL, 32'h7FFF_FFFF, 10'd0);
    send_item(ACT_READ, 32'h0, 10'd1023);
    set_frame(1, 2, 0);
    for (int i = 0; i < 4; i++) send_item(ACT_PIXEL, 32'h8000_0000, 10'd0);
    send_item(ACT_READ, 32'h0, 10'd0);
  endtask

  // The unused action must give no result.
  task automatic test_unused_action();
    send_item(ACT_NONE, $urandom, 10'h3FF);
    send_item(ACT_READ, 32'h0, 10'd1);
  endtask

  // Receiver holds off while reads pile up behind the output register.
  task automatic test_back_pressure();
    hold_off_cycles = 3000;
    for (int i = 0; i < 20; i++)
      send_item(($urandom_range(1)) ? ACT_READ : ACT_PIXEL, pick_pixel(), pick_bin());
    s_axis_tvalid <= 1'b0;
    wait (expected_reports.size() == 0);
  endtask

  // Random frames, mostly well-formed pixel runs with reads between them.
  task automatic test_random_frames(int items, int idle, int stall);
    int unsigned w, h, asp, k;
    tx_idle_pct = idle;
    rx_stall_pct = stall;
    case ($urandom_range(3))
      0: begin w = 512; h = 512; asp = $urandom; end
      1: begin w = $urandom_range(1023); h = $urandom_range(1023); asp = $urandom; end
      default: begin
        w = $urandom_range(2, 16); h = $urandom_range(2, 16); asp = $urandom_range(16384);
      end
    endcase
    set_frame(w, h, asp);
    send_item(ACT_CLEAR, 32'h0, 10'd0);
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(199);
      if (k < 2) send_item(ACT_CLEAR, $urandom, 10'($urandom));
      else if (k < 5) send_item(ACT_NONE, $urandom, 10'($urandom));
      else if (k < 40) send_item(ACT_READ, $urandom, pick_bin());
      else send_item(ACT_PIXEL, pick_pixel(), 10'($urandom));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_WIDTH;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= ACT_PIXEL;
    m_axis_tready <= 1'b0;
    width_reg = 512;
    height_reg = 512;
    aspect_reg = 4096;
    wipe_stores();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_after_reset();
    test_small_frame();
    test_clamp_and_saturation();
    test_unused_action();
    test_back_pressure();
    test_random_frames(330, 0, 0);
    test_random_frames(330, 65, 0);
    test_random_frames(330, 0, 65);
    test_random_frames(330, 36, 36);
    test_random_frames(60, 0, 0);

    s_axis_tvalid <= 1'b0;
    wait (expected_reports.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #30000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/aah_pkg.sv
hw/rtl/aah_ram.sv
hw/rtl/aah_isqrt.sv
hw/rtl/aah_div.sv
hw/rtl/azimuthal_average_histogram_unit.sv
bench/tb.sv
